@@ hw/rtl/nlms_pi_pkg.sv @@
// ----------------------------------------------------------------------------
// nlms_pi_pkg
// Shared types, codes and constants of the NLMS path identifier.
// ----------------------------------------------------------------------------
package nlms_pi_pkg;

    localparam int K_W       = 10;
    localparam int CFG_IDX_W = 3;
    localparam int DVD_W     = 60;
    localparam int DVS_W     = 58;

    localparam logic [CFG_IDX_W-1:0] REG_PROBE_AMP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd4;

    localparam logic [22:0] AMP_RESET       = 23'd838861;
    localparam logic [15:0] STEP_RESET      = 16'd655;
    localparam logic [31:0] DURATION_RESET  = 32'd48000;
    localparam logic [23:0] SMOOTHING_RESET = 24'd1398;
    localparam logic [31:0] NOISE_RESET     = 32'h2545F491;

    localparam logic [DVS_W-1:0] PWR_EPS  = 58'd70369;
    localparam logic [DVD_W-1:0] GAIN_LIM = 60'd1099511627775;
    localparam logic [47:0]      POWER_ONE = 48'd1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TAP_WR  = 2'd1,
        OP_TAP_RD  = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR_ALL,
        DP_CLEAR_HIST,
        DP_RESTART,
        DP_PROBE,
        DP_HIST_WR,
        DP_PASS_INIT,
        DP_MAC,
        DP_UPD,
        DP_RES,
        DP_MUL,
        DP_DIV_START,
        DP_GAIN,
        DP_PWR0,
        DP_PWR1,
        DP_PWR2,
        DP_PWR3,
        DP_TAP_WR,
        DP_TAP_RD,
        DP_TAP_CAP,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_PROBE,
        ST_HWR,
        ST_INIT,
        ST_MAC,
        ST_MDRAIN,
        ST_RES,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_GAIN,
        ST_UINIT,
        ST_UPD,
        ST_UDRAIN,
        ST_PW0,
        ST_PW1,
        ST_PW2,
        ST_PW3,
        ST_TWR,
        ST_TRD,
        ST_TCAP,
        ST_RST,
        ST_HCLR,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t         op;
        logic           path;
        logic [K_W-1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic adapt;
        logic div_busy;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

@@ hw/rtl/nlms_path_identifier_core.sv @@
// ----------------------------------------------------------------------------
// nlms_path_identifier_core
// NLMS identification of secondary and feedback paths driven by a noise probe.
// ----------------------------------------------------------------------------
// Adapting ticks run both paths through the single shared MAC pipeline
// and the serial gain divider.
// One transaction in work at a time; a finished result waits in the output
// register while the next transaction is accepted.
// After reset s_tready stays low during the max(SEC_TAPS, FB_TAPS, HIST_LEN)-entry clear sweep.
module nlms_path_identifier_core
    import nlms_pi_pkg::*;
#(
    parameter int SEC_TAPS = 128,
    parameter int FB_TAPS  = 128,
    parameter int HIST_LEN = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [87:0]          s_tdata,   // ref_sample, err_sample, tap_index, tap_data, pad
    input  logic [2:0]           s_tuser,   // opcode, path_select
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [199:0]         m_tdata,   // probe_out, secondary_residual,
                                            // feedback_residual, tap_read,
                                            // error_power, residual_power
    output logic                 m_tuser    // adapting
);

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    opcode_t            in_opcode;
    logic signed [23:0] out_probe, out_sres, out_fres;
    logic signed [31:0] out_tread;
    logic [47:0]        out_epow, out_rpow;

    assign cfg_ready = 1'b1;
    assign in_opcode = opcode_t'(s_tuser[1:0]);

    nlms_pi_ctrl #(
        .SEC_TAPS (SEC_TAPS),
        .FB_TAPS  (FB_TAPS),
        .HIST_LEN (HIST_LEN)
    ) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_opcode (in_opcode),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nlms_pi_dp #(
        .SEC_TAPS (SEC_TAPS),
        .FB_TAPS  (FB_TAPS),
        .HIST_LEN (HIST_LEN)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_opcode (in_opcode),
        .in_ref    ($signed(s_tdata[23:0])),
        .in_err    ($signed(s_tdata[47:24])),
        .in_sel    (s_tuser[2]),
        .in_idx    (s_tdata[54:48]),
        .in_data   ($signed(s_tdata[86:55])),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_probe (out_probe),
        .out_sres  (out_sres),
        .out_fres  (out_fres),
        .out_tread (out_tread),
        .out_epow  (out_epow),
        .out_rpow  (out_rpow),
        .out_adapt (m_tuser)
    );

    assign m_tdata = {out_rpow, out_epow, out_tread, out_fres, out_sres, out_probe};

endmodule

@@ hw/rtl/nlms_pi_div.sv @@
// ----------------------------------------------------------------------------
// nlms_pi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nlms_pi_div
    import nlms_pi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int DC_W = $clog2(DVD_W + 1);

    logic [DC_W-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : DVS_W'(rem_sh);
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DC_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/nlms_pi_dp.sv @@
// ----------------------------------------------------------------------------
// nlms_pi_dp
// Datapath: configuration, probe generator, history and tap memories,
// shared MAC pipeline, gain division, power trackers and result register.
// ----------------------------------------------------------------------------
module nlms_pi_dp
    import nlms_pi_pkg::*;
#(
    parameter int SEC_TAPS = 128,
    parameter int FB_TAPS  = 128,
    parameter int HIST_LEN = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  opcode_t              in_opcode,
    input  logic signed [23:0]   in_ref,
    input  logic signed [23:0]   in_err,
    input  logic                 in_sel,
    input  logic [6:0]           in_idx,
    input  logic signed [31:0]   in_data,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    input  logic                 m_tready,
    output logic                 out_valid,
    output logic signed [23:0]   out_probe,
    output logic signed [23:0]   out_sres,
    output logic signed [23:0]   out_fres,
    output logic signed [31:0]   out_tread,
    output logic [47:0]          out_epow,
    output logic [47:0]          out_rpow,
    output logic                 out_adapt
);

    localparam int SEC_AW  = (SEC_TAPS > 1) ? $clog2(SEC_TAPS) : 1;
    localparam int FB_AW   = (FB_TAPS > 1) ? $clog2(FB_TAPS) : 1;
    localparam int HIST_AW = $clog2(HIST_LEN);

    logic [22:0] amp_reg;
    logic [15:0] mu_reg;
    logic [31:0] dur_reg;
    logic [23:0] alpha_reg;
    logic [31:0] seed_reg;

    opcode_t            op_reg;
    logic signed [23:0] ref_reg, err_reg;
    logic               sel_reg;
    logic [6:0]         idx_reg;
    logic signed [31:0] data_reg;

    logic [31:0]        noise_reg;
    logic [HIST_AW-1:0] ptr_reg;
    logic [HIST_AW-1:0] hidx_reg;
    logic [31:0]        remain_reg;
    logic [47:0]        epow_reg, rpow_reg;
    logic               adapt_reg;

    logic signed [23:0] probe_reg, sres_reg, fres_reg;
    logic signed [31:0] tread_reg;

    logic signed [23:0] hist_mem [0:HIST_LEN-1];
    logic signed [31:0] sec_mem  [0:SEC_TAPS-1];
    logic signed [31:0] fb_mem   [0:FB_TAPS-1];

    logic signed [23:0] hist_q_reg;
    logic signed [31:0] sec_q_reg, fb_q_reg;
    logic               v1_reg, upd1_reg, path1_reg;
    logic [K_W-1:0]     k1_reg;
    logic               v2_reg, upd2_reg, path2_reg;
    logic [K_W-1:0]     k2_reg;
    logic signed [55:0] mac_tp_reg;
    logic [47:0]        mac_pp_reg;
    logic signed [48:0] upd_hi_reg;
    logic signed [40:0] upd_lo_reg;
    logic signed [31:0] tap2_reg;
    logic signed [53:0] acc_reg;
    logic [DVS_W-1:0]   pw_reg;

    logic signed [23:0] res_reg;
    logic signed [40:0] num_reg;
    logic signed [40:0] g_reg;

    logic [47:0]        esq_reg, rsq_reg;
    logic signed [48:0] de_reg, dr_reg;
    logic signed [49:0] ehi_reg, rhi_reg;
    logic [47:0]        elo_reg, rlo_reg;

    logic               m_valid_reg;
    logic signed [23:0] m_probe_reg, m_sres_reg, m_fres_reg;
    logic signed [31:0] m_tread_reg;
    logic [47:0]        m_epow_reg, m_rpow_reg;
    logic               m_adapt_reg;

    logic [31:0]        r1, r2, r3;
    logic signed [55:0] probe_prod;
    logic [K_W-1:0]     tap_addr;
    logic               k_in_sec, k_in_fb, k_in_hist, idx_in_sec, idx_in_fb;
    logic signed [31:0] tap_q;
    logic signed [55:0] tp_w;
    logic signed [47:0] pp_w;
    logic signed [48:0] hi_w;
    logic signed [40:0] lo_w;
    logic signed [64:0] hi_ext, lo_ext, gp_w, d_w;
    logic signed [65:0] tap_sum;
    logic signed [31:0] tap_sat;
    logic signed [54:0] diff_w;
    logic signed [23:0] sample_w;
    logic signed [23:0] res_sat;
    logic signed [40:0] num_w;
    logic [39:0]        num_mag;
    logic               div_start, div_busy, div_done;
    logic [DVD_W-1:0]   quotient;
    logic [DVD_W-1:0]   q_clamp;
    logic signed [47:0] esq_w, rsq_w;
    logic signed [24:0] alpha_s;
    logic signed [49:0] ehi_w, rhi_w;
    logic [47:0]        elo_w, rlo_w;
    logic signed [50:0] epow_w, rpow_w;

    logic               sec_we, fb_we, hist_we;
    logic [SEC_AW-1:0]  sec_wa;
    logic [FB_AW-1:0]   fb_wa;
    logic [HIST_AW-1:0] hist_wa;
    logic signed [31:0] sec_wd, fb_wd;
    logic signed [23:0] hist_wd;

    assign r1 = noise_reg ^ (noise_reg << 13);
    assign r2 = r1 ^ (r1 >> 17);
    assign r3 = r2 ^ (r2 << 5);
    assign probe_prod = $signed({1'b0, amp_reg}) * $signed(r3);

    assign k_in_sec   = 32'(cmd.k) < 32'(SEC_TAPS);
    assign k_in_fb    = 32'(cmd.k) < 32'(FB_TAPS);
    assign k_in_hist  = 32'(cmd.k) < 32'(HIST_LEN);
    assign idx_in_sec = 32'(idx_reg) < 32'(SEC_TAPS);
    assign idx_in_fb  = 32'(idx_reg) < 32'(FB_TAPS);
    assign tap_addr   = (cmd.op == DP_TAP_RD) ? K_W'(idx_reg) : cmd.k;

    assign tap_q = path1_reg ? fb_q_reg : sec_q_reg;
    assign tp_w  = tap_q * hist_q_reg;
    assign pp_w  = hist_q_reg * hist_q_reg;
    assign hi_w  = $signed(g_reg[40:16]) * hist_q_reg;
    assign lo_w  = $signed({1'b0, g_reg[15:0]}) * hist_q_reg;

    assign hi_ext  = upd_hi_reg;
    assign lo_ext  = upd_lo_reg;
    assign gp_w    = (hi_ext <<< 16) + lo_ext;
    assign d_w     = gp_w >>> 8;
    assign tap_sum = 66'(tap2_reg) + 66'(d_w);
    assign tap_sat = (tap_sum > 66'sd2147483647) ? 32'sh7FFFFFFF :
                     (tap_sum < -66'sd2147483648) ? 32'sh80000000 : tap_sum[31:0];

    assign sample_w = cmd.path ? ref_reg : err_reg;
    assign diff_w   = 55'(sample_w) - 55'(acc_reg >>> 16);
    assign res_sat  = (diff_w > 55'sd8388607) ? 24'sh7FFFFF :
                      (diff_w < -55'sd8388608) ? 24'sh800000 : diff_w[23:0];

    assign num_w     = $signed({1'b0, mu_reg}) * res_reg;
    assign num_mag   = num_reg[40] ? 40'(-num_reg) : num_reg[39:0];
    assign div_start = cmd.op == DP_DIV_START;
    assign q_clamp   = (quotient > GAIN_LIM) ? GAIN_LIM : quotient;

    assign esq_w   = err_reg * err_reg;
    assign rsq_w   = sres_reg * sres_reg;
    assign alpha_s = $signed({1'b0, alpha_reg});
    assign ehi_w   = alpha_s * $signed(de_reg[48:24]);
    assign rhi_w   = alpha_s * $signed(dr_reg[48:24]);
    assign elo_w   = alpha_reg * de_reg[23:0];
    assign rlo_w   = alpha_reg * dr_reg[23:0];
    assign epow_w  = $signed({3'b0, epow_reg}) + 51'(ehi_reg) + $signed({27'b0, elo_reg[47:24]});
    assign rpow_w  = $signed({3'b0, rpow_reg}) + 51'(rhi_reg) + $signed({27'b0, rlo_reg[47:24]});

    nlms_pi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_mag, 20'b0}),
        .divisor  (pw_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        sec_we  = 1'b0;
        sec_wa  = cmd.k[SEC_AW-1:0];
        sec_wd  = '0;
        fb_we   = 1'b0;
        fb_wa   = cmd.k[FB_AW-1:0];
        fb_wd   = '0;
        hist_we = 1'b0;
        hist_wa = cmd.k[HIST_AW-1:0];
        hist_wd = '0;
        if (cmd.op == DP_CLEAR_ALL)
        begin
            sec_we = k_in_sec;
            fb_we  = k_in_fb;
        end
        else if (cmd.op == DP_TAP_WR)
        begin
            sec_we = !sel_reg && idx_in_sec;
            fb_we  = sel_reg && idx_in_fb;
            sec_wa = SEC_AW'(idx_reg);
            fb_wa  = FB_AW'(idx_reg);
            sec_wd = data_reg;
            fb_wd  = data_reg;
        end
        else if (v2_reg && upd2_reg)
        begin
            sec_we = !path2_reg;
            fb_we  = path2_reg;
            sec_wa = k2_reg[SEC_AW-1:0];
            fb_wa  = k2_reg[FB_AW-1:0];
            sec_wd = tap_sat;
            fb_wd  = tap_sat;
        end
        if (cmd.op == DP_CLEAR_ALL || cmd.op == DP_CLEAR_HIST)
        begin
            hist_we = k_in_hist;
        end
        else if (cmd.op == DP_HIST_WR)
        begin
            hist_we = 1'b1;
            hist_wa = ptr_reg;
            hist_wd = probe_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sec_we)
        begin
            sec_mem[sec_wa] <= sec_wd;
        end
        sec_q_reg <= sec_mem[tap_addr[SEC_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            fb_mem[fb_wa] <= fb_wd;
        end
        fb_q_reg <= fb_mem[tap_addr[FB_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        hist_q_reg <= hist_mem[hidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg     <= AMP_RESET;
            mu_reg      <= STEP_RESET;
            dur_reg     <= DURATION_RESET;
            alpha_reg   <= SMOOTHING_RESET;
            seed_reg    <= NOISE_RESET;
            noise_reg   <= NOISE_RESET;
            ptr_reg     <= '0;
            hidx_reg    <= '0;
            remain_reg  <= '0;
            epow_reg    <= POWER_ONE;
            rpow_reg    <= POWER_ONE;
            adapt_reg   <= 1'b0;
            op_reg      <= OP_TICK;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROBE_AMP: amp_reg   <= cfg_data[22:0];
                    REG_STEP_SIZE: mu_reg    <= cfg_data[15:0];
                    REG_DURATION:  dur_reg   <= cfg_data;
                    REG_SMOOTHING: alpha_reg <= cfg_data[23:0];
                    REG_SEED:      seed_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            v1_reg <= cmd.op == DP_MAC || cmd.op == DP_UPD;
            v2_reg <= v1_reg;
            if (cmd.op == DP_MAC || cmd.op == DP_UPD)
            begin
                hidx_reg <= (hidx_reg == HIST_AW'(HIST_LEN - 1)) ? '0 : hidx_reg + 1'b1;
            end
            if (cmd.op == DP_RESULT)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                DP_LOAD:
                begin
                    op_reg <= in_opcode;
                end
                DP_RESTART:
                begin
                    noise_reg  <= seed_reg;
                    remain_reg <= dur_reg;
                    ptr_reg    <= '0;
                    epow_reg   <= POWER_ONE;
                    rpow_reg   <= POWER_ONE;
                end
                DP_PROBE:
                begin
                    noise_reg <= r3;
                    ptr_reg   <= (ptr_reg == '0) ? HIST_AW'(HIST_LEN - 1) : ptr_reg - 1'b1;
                    adapt_reg <= remain_reg != '0;
                end
                DP_HIST_WR:
                begin
                    if (adapt_reg)
                    begin
                        remain_reg <= remain_reg - 1'b1;
                    end
                end
                DP_PASS_INIT:
                begin
                    hidx_reg <= ptr_reg;
                end
                DP_PWR3:
                begin
                    epow_reg <= epow_w[47:0];
                    rpow_reg <= rpow_w[47:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        upd1_reg   <= cmd.op == DP_UPD;
        path1_reg  <= cmd.path;
        k1_reg     <= cmd.k;
        upd2_reg   <= upd1_reg;
        path2_reg  <= path1_reg;
        k2_reg     <= k1_reg;
        mac_tp_reg <= tp_w;
        mac_pp_reg <= pp_w[47:0];
        upd_hi_reg <= hi_w;
        upd_lo_reg <= lo_w;
        tap2_reg   <= tap_q;
        if (v2_reg && !upd2_reg)
        begin
            acc_reg <= acc_reg + 54'(mac_tp_reg >>> 12);
            pw_reg  <= pw_reg + DVS_W'(mac_pp_reg);
        end
        case (cmd.op)
            DP_LOAD:
            begin
                ref_reg   <= in_ref;
                err_reg   <= in_err;
                sel_reg   <= in_sel;
                idx_reg   <= in_idx;
                data_reg  <= in_data;
                probe_reg <= '0;
                sres_reg  <= '0;
                fres_reg  <= '0;
                tread_reg <= '0;
            end
            DP_PROBE:
            begin
                probe_reg <= probe_prod[54:31];
            end
            DP_PASS_INIT:
            begin
                acc_reg <= '0;
                pw_reg  <= PWR_EPS;
            end
            DP_RES:
            begin
                res_reg <= res_sat;
                if (cmd.path)
                begin
                    fres_reg <= res_sat;
                end
                else
                begin
                    sres_reg <= res_sat;
                end
            end
            DP_MUL:
            begin
                num_reg <= num_w;
            end
            DP_GAIN:
            begin
                g_reg <= num_reg[40] ? -$signed({1'b0, q_clamp[39:0]})
                                     : $signed({1'b0, q_clamp[39:0]});
            end
            DP_PWR0:
            begin
                esq_reg <= esq_w[47:0];
                rsq_reg <= rsq_w[47:0];
            end
            DP_PWR1:
            begin
                de_reg <= $signed({1'b0, esq_reg}) - $signed({1'b0, epow_reg});
                dr_reg <= $signed({1'b0, rsq_reg}) - $signed({1'b0, rpow_reg});
            end
            DP_PWR2:
            begin
                ehi_reg <= ehi_w;
                rhi_reg <= rhi_w;
                elo_reg <= elo_w;
                rlo_reg <= rlo_w;
            end
            DP_TAP_CAP:
            begin
                if (sel_reg)
                begin
                    tread_reg <= idx_in_fb ? fb_q_reg : '0;
                end
                else
                begin
                    tread_reg <= idx_in_sec ? sec_q_reg : '0;
                end
            end
            DP_RESULT:
            begin
                m_probe_reg <= probe_reg;
                m_sres_reg  <= sres_reg;
                m_fres_reg  <= fres_reg;
                m_tread_reg <= tread_reg;
                m_epow_reg  <= epow_reg;
                m_rpow_reg  <= rpow_reg;
                m_adapt_reg <= (op_reg == OP_TICK) ? adapt_reg : (remain_reg != '0);
            end
            default: ;
        endcase
    end

    assign sts.adapt    = adapt_reg;
    assign sts.div_busy = div_busy;
    assign sts.div_done = div_done;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign out_valid = m_valid_reg;
    assign out_probe = m_probe_reg;
    assign out_sres  = m_sres_reg;
    assign out_fres  = m_fres_reg;
    assign out_tread = m_tread_reg;
    assign out_epow  = m_epow_reg;
    assign out_rpow  = m_rpow_reg;
    assign out_adapt = m_adapt_reg;

endmodule

@@ hw/rtl/nlms_pi_ctrl.sv @@
// ----------------------------------------------------------------------------
// nlms_pi_ctrl
// Sequencer: steps the datapath through clearing, ticks, passes, restarts and tap access.
// ----------------------------------------------------------------------------
module nlms_pi_ctrl
    import nlms_pi_pkg::*;
#(
    parameter int SEC_TAPS = 128,
    parameter int FB_TAPS  = 128,
    parameter int HIST_LEN = 128
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  opcode_t s_opcode,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam int MAX_TH = (SEC_TAPS > FB_TAPS) ? SEC_TAPS : FB_TAPS;
    localparam int MAXN   = (MAX_TH > HIST_LEN) ? MAX_TH : HIST_LEN;

    ctrl_state_t    state_reg, state_next;
    logic [K_W-1:0] k_reg, k_next;
    logic           path_reg, path_next;
    logic [1:0]     wait_reg, wait_next;
    logic           k_last;

    assign k_last = path_reg ? (k_reg == K_W'(FB_TAPS - 1)) : (k_reg == K_W'(SEC_TAPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            k_reg     <= '0;
            path_reg  <= 1'b0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            path_reg  <= path_next;
            wait_reg  <= wait_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        path_next  = path_reg;
        wait_next  = wait_reg;
        s_tready   = 1'b0;
        cmd.op     = DP_NOP;
        cmd.path   = path_reg;
        cmd.k      = k_reg;
        case (state_reg)
            ST_CLR:
            begin
                cmd.op = DP_CLEAR_ALL;
                k_next = k_reg + 1'b1;
                if (k_reg == K_W'(MAXN - 1))
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = DP_LOAD;
                    case (s_opcode)
                        OP_TICK:    state_next = ST_PROBE;
                        OP_TAP_WR:  state_next = ST_TWR;
                        OP_TAP_RD:  state_next = ST_TRD;
                        OP_RESTART: state_next = ST_RST;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PROBE:
            begin
                cmd.op     = DP_PROBE;
                state_next = ST_HWR;
            end
            ST_HWR:
            begin
                cmd.op     = DP_HIST_WR;
                path_next  = 1'b0;
                state_next = sts.adapt ? ST_INIT : ST_DONE;
            end
            ST_INIT:
            begin
                cmd.op     = DP_PASS_INIT;
                k_next     = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.op = DP_MAC;
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    wait_next  = '0;
                    state_next = ST_MDRAIN;
                end
            end
            ST_MDRAIN:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == 2'd2)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                cmd.op     = DP_RES;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = DP_MUL;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.op     = DP_DIV_START;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.op     = DP_GAIN;
                state_next = ST_UINIT;
            end
            ST_UINIT:
            begin
                cmd.op     = DP_PASS_INIT;
                k_next     = '0;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op = DP_UPD;
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    wait_next  = '0;
                    state_next = ST_UDRAIN;
                end
            end
            ST_UDRAIN:
            begin
                wait_next = wait_reg + 1'b1;
                if (wait_reg == 2'd2)
                begin
                    if (path_reg)
                    begin
                        state_next = ST_PW0;
                    end
                    else
                    begin
                        path_next  = 1'b1;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_PW0:
            begin
                cmd.op     = DP_PWR0;
                state_next = ST_PW1;
            end
            ST_PW1:
            begin
                cmd.op     = DP_PWR1;
                state_next = ST_PW2;
            end
            ST_PW2:
            begin
                cmd.op     = DP_PWR2;
                state_next = ST_PW3;
            end
            ST_PW3:
            begin
                cmd.op     = DP_PWR3;
                state_next = ST_DONE;
            end
            ST_TWR:
            begin
                cmd.op     = DP_TAP_WR;
                state_next = ST_DONE;
            end
            ST_TRD:
            begin
                cmd.op     = DP_TAP_RD;
                state_next = ST_TCAP;
            end
            ST_TCAP:
            begin
                cmd.op     = DP_TAP_CAP;
                state_next = ST_DONE;
            end
            ST_RST:
            begin
                cmd.op     = DP_RESTART;
                k_next     = '0;
                state_next = ST_HCLR;
            end
            ST_HCLR:
            begin
                cmd.op = DP_CLEAR_HIST;
                k_next = k_reg + 1'b1;
                if (k_reg == K_W'(HIST_LEN - 1))
                begin
                    k_next     = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = DP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_DIV_START) |-> !sts.div_busy)
        else $error("divider started while busy");

    a_div_done_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVW && sts.div_done) |=> (state_reg == ST_GAIN))
        else $error("quotient not taken after divide");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR && state_next == ST_IDLE) |-> (k_reg == K_W'(MAXN - 1)))
        else $error("clearing sweep cut short");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RESULT) |-> sts.out_free)
        else $error("result overwrote pending transaction");
`endif

endmodule
